// ===== design/assert_macros.svh =====
// assertion helpers used by the tokenizer back end (ctok_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define CTOK_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("tokenizer check failed");

// a implies b in the same cycle
`define CTOK_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tokenizer check failed");

// a implies b in the next cycle
`define CTOK_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tokenizer check failed");

`endif

// ===== design/ctok_pkg.sv =====
`default_nettype none

package ctok_pkg;

  localparam int CHAR_W = 16;
  localparam int CNT_W  = 8;

  localparam logic [CHAR_W-1:0] C_COMMA = 16'h002C;
  localparam logic [CHAR_W-1:0] C_QUOTE = 16'h0022;
  localparam logic [CHAR_W-1:0] C_TAB   = 16'h0009;
  localparam logic [CHAR_W-1:0] C_CR    = 16'h000D;
  localparam logic [CHAR_W-1:0] C_LF    = 16'h000A;
  localparam logic [CHAR_W-1:0] C_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] C_NUL   = 16'h0000;

  // character classes worked out in the front
  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_SPACE = 3'd1;
  localparam logic [2:0] CLS_TAB   = 3'd2;
  localparam logic [2:0] CLS_COMMA = 3'd3;
  localparam logic [2:0] CLS_QUOTE = 3'd4;
  localparam logic [2:0] CLS_NUL   = 3'd5;
  localparam logic [2:0] CLS_CR    = 3'd6;
  localparam logic [2:0] CLS_LF    = 3'd7;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [2:0]        cls;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [CNT_W-1:0]  position;
    logic [CHAR_W-1:0] out_char;
    logic [CNT_W-1:0]  length;
    logic [CHAR_W-1:0] lead_code;
    logic              overflow;
    logic              line_end;
  } res_t;

endpackage

`default_nettype wire

// ===== design/ctok_front.sv =====
`default_nettype none

module ctok_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [ctok_pkg::CHAR_W-1:0]   ch,
  output logic                               q_valid,
  output ctok_pkg::item_t                    q_item,
  input  wire logic                          q_pop
);

  localparam int IDX_W = $clog2(ctok_pkg::QDEPTH);

  ctok_pkg::item_t       mem [ctok_pkg::QDEPTH];
  logic [IDX_W-1:0]      wr_ptr;
  logic [IDX_W-1:0]      rd_ptr;
  logic [IDX_W-1:0]      rd_next;
  logic [IDX_W:0]        count;
  logic [2:0]            cls;
  logic                  do_push;
  logic                  do_pop;

  always_comb begin
    unique case (ch)
      ctok_pkg::C_SPACE: cls = ctok_pkg::CLS_SPACE;
      ctok_pkg::C_TAB:   cls = ctok_pkg::CLS_TAB;
      ctok_pkg::C_COMMA: cls = ctok_pkg::CLS_COMMA;
      ctok_pkg::C_QUOTE: cls = ctok_pkg::CLS_QUOTE;
      ctok_pkg::C_NUL:   cls = ctok_pkg::CLS_NUL;
      ctok_pkg::C_CR:    cls = ctok_pkg::CLS_CR;
      ctok_pkg::C_LF:    cls = ctok_pkg::CLS_LF;
      default:           cls = ctok_pkg::CLS_OTHER;
    endcase
  end

  assign full    = (count == (IDX_W+1)'(ctok_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;
  assign rd_next = rd_ptr + IDX_W'(do_pop);

  // head read is registered: load the entry one ahead when popping, and
  // take the incoming word directly when it lands on the next head slot
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= '{ch: ch, cls: cls};
    end
    if (do_push && (wr_ptr == rd_next)) begin
      q_item <= '{ch: ch, cls: cls};
    end else begin
      q_item <= mem[rd_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      rd_ptr <= rd_next;
      count <= count + (IDX_W+1)'(do_push) - (IDX_W+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== design/ctok_back.sv =====
`default_nettype none

`include "assert_macros.svh"

module ctok_back #(
  parameter int PARAM_LEN = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  input  wire ctok_pkg::item_t              q_item,
  output logic                              q_pop,
  output logic                              empty,
  input  wire logic                         pop,
  output ctok_pkg::res_t                    res
);

  localparam logic [2:0] PH_SKIP     = 3'd0;
  localparam logic [2:0] PH_UNQ      = 3'd1;
  localparam logic [2:0] PH_QIN      = 3'd2;
  localparam logic [2:0] PH_QQ       = 3'd3;
  localparam logic [2:0] PH_QAFTER   = 3'd4;
  localparam logic [2:0] PH_AFTER_CR = 3'd5;
  localparam logic [2:0] PH_AFTER_LF = 3'd6;

  localparam int CW = ctok_pkg::CNT_W;
  localparam logic [CW-1:0] LIM = CW'(PARAM_LEN - 1);

  logic [2:0]                    phase, phase_next, eff_phase;
  logic [CW-1:0]                 write_count, write_count_next;
  logic [CW-1:0]                 trimmed_count, trimmed_count_next;
  logic [ctok_pkg::CHAR_W-1:0]   first_code, first_code_next;
  logic                          overflow_seen, overflow_seen_next;

  logic                          step;
  logic [ctok_pkg::CHAR_W-1:0]   c;
  logic [2:0]                    cls;
  logic                          is_eol, is_delim, pair_swallow;
  logic                          do_done, do_write, do_keep;
  logic [CW-1:0]                 done_len;
  logic [ctok_pkg::CHAR_W-1:0]   done_lead;
  logic                          done_ovf;
  logic [CW-1:0]                 wr_pos;
  logic [ctok_pkg::CHAR_W-1:0]   wr_char, keep_char;
  ctok_pkg::res_t                res_new;

  ctok_pkg::res_t                ofifo [2];
  logic                          o_wr, o_rd;
  logic [1:0]                    o_count;
  logic                          o_push, o_pop;

  assign c   = q_item.ch;
  assign cls = q_item.cls;

  assign is_eol   = (cls == ctok_pkg::CLS_NUL) || (cls == ctok_pkg::CLS_CR) ||
                    (cls == ctok_pkg::CLS_LF);
  assign is_delim = is_eol || (cls == ctok_pkg::CLS_COMMA) || (cls == ctok_pkg::CLS_TAB);

  // a step runs whenever an input item waits and the output queue has a free slot
  assign step  = q_valid && (o_count != 2'd2);
  assign q_pop = step;

  assign pair_swallow = ((phase == PH_AFTER_CR) && (cls == ctok_pkg::CLS_LF)) ||
                        ((phase == PH_AFTER_LF) && (cls == ctok_pkg::CLS_CR));
  assign eff_phase = ((phase == PH_AFTER_CR) || (phase == PH_AFTER_LF)) ? PH_SKIP : phase;

  always_comb begin
    phase_next         = phase;
    write_count_next   = write_count;
    trimmed_count_next = trimmed_count;
    first_code_next    = first_code;
    overflow_seen_next = overflow_seen;
    do_done   = 1'b0;
    do_write  = 1'b0;
    do_keep   = 1'b0;
    done_len  = '0;
    done_lead = '0;
    done_ovf  = 1'b0;
    wr_pos    = '0;
    wr_char   = '0;
    keep_char = c;

    if (pair_swallow) begin
      phase_next = PH_SKIP;
    end else begin
      unique case (eff_phase)
        PH_SKIP: begin
          phase_next = PH_SKIP;
          if (cls == ctok_pkg::CLS_SPACE || cls == ctok_pkg::CLS_TAB) begin
            phase_next = PH_SKIP;
          end else if (is_eol) begin
            do_done = 1'b1;
          end else if (cls == ctok_pkg::CLS_COMMA) begin
            do_done   = 1'b1;
            done_lead = ctok_pkg::C_COMMA;
          end else if (cls == ctok_pkg::CLS_QUOTE) begin
            phase_next = PH_QIN;
          end else begin
            phase_next         = PH_UNQ;
            first_code_next    = c;
            write_count_next   = CW'(1);
            trimmed_count_next = CW'(1);
            do_write = 1'b1;
            wr_pos   = '0;
            wr_char  = c;
          end
        end
        PH_UNQ: begin
          if (is_delim) begin
            do_done   = 1'b1;
            done_len  = trimmed_count;
            done_lead = first_code;
          end else if (write_count < LIM) begin
            write_count_next = write_count + 1'b1;
            if (cls != ctok_pkg::CLS_SPACE) trimmed_count_next = write_count + 1'b1;
            do_write = 1'b1;
            wr_pos   = write_count;
            wr_char  = c;
          end
        end
        PH_QIN: begin
          if (is_eol) begin
            do_done   = 1'b1;
            done_len  = write_count;
            done_lead = first_code;
            done_ovf  = overflow_seen;
          end else if (cls == ctok_pkg::CLS_QUOTE) begin
            phase_next = PH_QQ;
          end else begin
            do_keep = 1'b1;
          end
        end
        PH_QQ: begin
          if (cls == ctok_pkg::CLS_QUOTE) begin
            phase_next = PH_QIN;
            do_keep    = 1'b1;
            keep_char  = ctok_pkg::C_QUOTE;
          end else if (is_delim) begin
            do_done   = 1'b1;
            done_len  = write_count;
            done_lead = first_code;
            done_ovf  = overflow_seen;
          end else begin
            phase_next = PH_QAFTER;
          end
        end
        PH_QAFTER: begin
          if (is_delim) begin
            do_done   = 1'b1;
            done_len  = write_count;
            done_lead = first_code;
            done_ovf  = overflow_seen;
          end
        end
        default: begin
          phase_next         = PH_SKIP;
          write_count_next   = '0;
          trimmed_count_next = '0;
          first_code_next    = '0;
          overflow_seen_next = 1'b0;
        end
      endcase
    end

    // quoted character kept, or dropped with overflow once full
    if (do_keep) begin
      if (write_count >= LIM) begin
        overflow_seen_next = 1'b1;
      end else begin
        if (write_count == '0) first_code_next = keep_char;
        write_count_next = write_count + 1'b1;
        do_write = 1'b1;
        wr_pos   = write_count;
        wr_char  = keep_char;
      end
    end

    if (do_done) begin
      write_count_next   = '0;
      trimmed_count_next = '0;
      first_code_next    = '0;
      overflow_seen_next = 1'b0;
      if (cls == ctok_pkg::CLS_CR)      phase_next = PH_AFTER_CR;
      else if (cls == ctok_pkg::CLS_LF) phase_next = PH_AFTER_LF;
      else                              phase_next = PH_SKIP;
    end
  end

  always_comb begin
    res_new.kind      = do_done;
    res_new.position  = do_done ? '0 : wr_pos;
    res_new.out_char  = do_done ? '0 : wr_char;
    res_new.length    = done_len;
    res_new.lead_code = done_lead;
    res_new.overflow  = done_ovf;
    res_new.line_end  = do_done && is_eol;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SKIP;
      write_count   <= '0;
      trimmed_count <= '0;
      first_code    <= '0;
      overflow_seen <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      write_count   <= write_count_next;
      trimmed_count <= trimmed_count_next;
      first_code    <= first_code_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // two-word output queue parts the step logic from the consumer
  assign o_push = step && (do_done || do_write);
  assign o_pop  = pop && !empty;
  assign empty  = (o_count == 2'd0);
  assign res    = ofifo[o_rd];

  always_ff @(posedge clk) begin
    if (o_push) ofifo[o_wr] <= res_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= 1'b0;
      o_rd    <= 1'b0;
      o_count <= 2'd0;
    end else begin
      if (o_push) o_wr <= !o_wr;
      if (o_pop)  o_rd <= !o_rd;
      o_count <= o_count + 2'(o_push) - 2'(o_pop);
    end
  end

  `CTOK_ASSERT_NEVER(a_ocount_range, clk, rst, o_count == 2'd3)
  `CTOK_ASSERT_IMP(a_trim_le_count, clk, rst, 1'b1, trimmed_count <= write_count)
  `CTOK_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, write_count <= LIM)
  `CTOK_ASSERT_NEXT(a_done_clears, clk, rst, step && do_done, write_count == '0)

endmodule

`default_nettype wire

// ===== design/comma_parameter_tokenizer.sv =====
// channel  | handshake        | words
// ---------+------------------+-----------------------------------------------
// input    | push / full      | ch
// result   | pop / empty      | out_kind position out_char length lead_code
//          |                  | overflow line_end
//
// one character per cycle sustained while the output queue has a free slot; a
// result passes the input queue, then the back step and its output queue.
// the single phase/counter update in the back step sets the rate.
// rst is synchronous: both queues empty, phase back to leading space skip.
// a stalled consumer fills the two-word output queue, then the four-word
// input queue, and full rises only when both are taken.
`default_nettype none

module comma_parameter_tokenizer #(
  parameter int PARAM_LEN = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [15:0]  ch,
  output logic              empty,
  input  wire logic         pop,
  output logic              out_kind,
  output logic [7:0]        position,
  output logic [15:0]       out_char,
  output logic [7:0]        length,
  output logic [15:0]       lead_code,
  output logic              overflow,
  output logic              line_end
);

  logic            q_valid;
  logic            q_pop;
  ctok_pkg::item_t q_item;
  ctok_pkg::res_t  res;

  ctok_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .ch      (ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  ctok_back #(
    .PARAM_LEN (PARAM_LEN)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign out_kind  = res.kind;
  assign position  = res.position;
  assign out_char  = res.out_char;
  assign length    = res.length;
  assign lead_code = res.lead_code;
  assign overflow  = res.overflow;
  assign line_end  = res.line_end;

endmodule

`default_nettype wire
